/* design/assert_macros.svh */
// Assertion helpers shared by the checker files.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/atr_pkg.sv */
`timescale 1ns / 1ps

package atr_pkg;

    // Input mode codes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_RUN      = 3'd0;
    localparam logic [2:0] ST_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_OK       = 3'd2;
    localparam logic [2:0] ST_ERROR    = 3'd3;
    localparam logic [2:0] ST_ATTACHED = 3'd4;
    localparam logic [2:0] ST_NOTICE   = 3'd5;
    localparam logic [2:0] ST_BAD      = 3'd6;

    localparam logic [7:0]  BYTE_ABORT = 8'hFF;
    localparam logic [7:0]  BYTE_LF    = 8'h0A;
    localparam logic [10:0] BUF_DEPTH  = 11'd1024;

    // Pattern lengths
    localparam logic [2:0] OK_LEN  = 3'd4;
    localparam logic [2:0] ERR_LEN = 3'd7;
    localparam logic [3:0] ATT_LEN = 4'd10;
    localparam logic [2:0] NT_LEN  = 3'd6;

    typedef enum logic [2:0] {
        CMD_START,
        CMD_BYTE,
        CMD_ABORT,
        CMD_TICK,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic [10:0] room;
        logic [15:0] tmo;
    } cmd_t;

    // "OK\r\n"
    function automatic logic [7:0] ok_char(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0:    c = 8'h4F;
            3'd1:    c = 8'h4B;
            3'd2:    c = 8'h0D;
            3'd3:    c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "ERROR\r\n"
    function automatic logic [7:0] err_char(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0:    c = 8'h45;
            3'd1:    c = 8'h52;
            3'd2:    c = 8'h52;
            3'd3:    c = 8'h4F;
            3'd4:    c = 8'h52;
            3'd5:    c = 8'h0D;
            3'd6:    c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "+CGATT:1\r\n"
    function automatic logic [7:0] att_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0:    c = 8'h2B;
            4'd1:    c = 8'h43;
            4'd2:    c = 8'h47;
            4'd3:    c = 8'h41;
            4'd4:    c = 8'h54;
            4'd5:    c = 8'h54;
            4'd6:    c = 8'h3A;
            4'd7:    c = 8'h31;
            4'd8:    c = 8'h0D;
            4'd9:    c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "+NNMI:"
    function automatic logic [7:0] nt_char(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0:    c = 8'h2B;
            3'd1:    c = 8'h4E;
            3'd2:    c = 8'h4E;
            3'd3:    c = 8'h4D;
            3'd4:    c = 8'h49;
            3'd5:    c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* design/atr_front.sv */
`timescale 1ns / 1ps

module atr_front (
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    mode,
    input  logic [7:0]    rx_byte,
    input  logic [10:0]   capacity,
    input  logic [15:0]   timeout_ms,
    input  logic          q_full,
    output logic          push,
    output atr_pkg::cmd_t cmd
);
    import atr_pkg::*;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        cmd.data = rx_byte;
        cmd.tmo  = timeout_ms;
        // clamp capacity to the buffer size
        cmd.room = (capacity > BUF_DEPTH) ? BUF_DEPTH : capacity;
        case (mode)
            MODE_START: cmd.kind = CMD_START;
            MODE_BYTE:  cmd.kind = (rx_byte == BYTE_ABORT) ? CMD_ABORT : CMD_BYTE;
            MODE_TICK:  cmd.kind = CMD_TICK;
            default:    cmd.kind = CMD_NOP;
        endcase
    end

endmodule

/* design/atr_queue.sv */
`timescale 1ns / 1ps

module atr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  atr_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output atr_pkg::cmd_t q_cmd
);
    import atr_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* design/atr_back.sv */
`timescale 1ns / 1ps

module atr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  atr_pkg::cmd_t q_cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          done_res,
    output logic [2:0]    status,
    output logic          store_enable,
    output logic [9:0]    store_index,
    output logic [7:0]    store_byte,
    output logic          echo_enable,
    output logic [10:0]   received_length
);
    import atr_pkg::*;

    logic        active_reg,  active_next;
    logic [2:0]  ok_reg,      ok_next;
    logic [2:0]  err_reg,     err_next;
    logic [3:0]  att_reg,     att_next;
    logic [2:0]  nt_reg,      nt_next;
    logic [10:0] count_reg,   count_next;
    logic [10:0] room_reg,    room_next;
    logic [15:0] idle_reg,    idle_next;

    logic        out_valid_reg;
    logic        done_reg;
    logic [2:0]  status_reg;
    logic        st_en_reg;
    logic [9:0]  st_idx_reg;
    logic [7:0]  st_byte_reg;
    logic        echo_reg;
    logic [10:0] len_reg;

    logic        r_done;
    logic [2:0]  r_status;
    logic        r_st_en;
    logic [9:0]  r_st_idx;
    logic [7:0]  r_st_byte;
    logic        r_echo;

    logic [7:0]  b;
    logic        ok_hit,  err_hit,  att_hit,  nt_hit;
    logic [2:0]  ok_adv,  err_adv,  nt_adv;
    logic [3:0]  att_adv;
    logic [2:0]  ok_inc,  err_inc,  nt_inc;
    logic [3:0]  att_inc;
    logic        ok_eq,   err_eq,   att_eq,   nt_eq;
    logic        ok_ge,   err_ge,   att_ge,   nt_ge;
    logic [15:0] idle_dec;

    assign pop = q_valid && (!out_valid_reg || out_ready);
    assign b   = q_cmd.data;

    // Matcher steps, evaluated in parallel; the priority chain picks which commit.
    always_comb
    begin
        ok_ge   = (ok_reg >= OK_LEN);
        ok_eq   = (ok_char(ok_reg) == b);
        ok_inc  = ok_reg + 3'd1;
        ok_hit  = ok_ge || (ok_eq && (ok_inc == OK_LEN));
        ok_adv  = ok_ge ? ok_reg : (ok_eq ? ok_inc : 3'd0);

        err_ge  = (err_reg >= ERR_LEN);
        err_eq  = (err_char(err_reg) == b);
        err_inc = err_reg + 3'd1;
        err_hit = err_ge || (err_eq && (err_inc == ERR_LEN));
        err_adv = err_ge ? err_reg : (err_eq ? err_inc : 3'd0);

        att_ge  = (att_reg >= ATT_LEN);
        att_eq  = (att_char(att_reg) == b);
        att_inc = att_reg + 4'd1;
        att_hit = att_ge || (att_eq && (att_inc == ATT_LEN));
        att_adv = att_ge ? att_reg : (att_eq ? att_inc : 4'd0);

        // once the notice header is seen, wait for the line feed
        nt_ge   = (nt_reg >= NT_LEN);
        nt_eq   = (nt_char(nt_reg) == b);
        nt_inc  = nt_reg + 3'd1;
        nt_hit  = nt_ge && (b == BYTE_LF);
        nt_adv  = nt_ge ? nt_reg : (nt_eq ? nt_inc : 3'd0);

        idle_dec = (idle_reg != 16'd0) ? (idle_reg - 16'd1) : idle_reg;
    end

    always_comb
    begin
        active_next = active_reg;
        ok_next     = ok_reg;
        err_next    = err_reg;
        att_next    = att_reg;
        nt_next     = nt_reg;
        count_next  = count_reg;
        room_next   = room_reg;
        idle_next   = idle_reg;
        r_done      = 1'b0;
        r_status    = ST_RUN;
        r_st_en     = 1'b0;
        r_st_idx    = 10'd0;
        r_st_byte   = 8'd0;
        r_echo      = 1'b0;

        case (q_cmd.kind)
            CMD_START:
            begin
                active_next = 1'b1;
                ok_next     = 3'd0;
                err_next    = 3'd0;
                att_next    = 4'd0;
                nt_next     = 3'd0;
                count_next  = 11'd0;
                room_next   = q_cmd.room;
                idle_next   = q_cmd.tmo;
            end
            CMD_ABORT:
            begin
                if (active_reg)
                begin
                    r_done      = 1'b1;
                    r_status    = ST_BAD;
                    active_next = 1'b0;
                end
            end
            CMD_BYTE:
            begin
                if (active_reg)
                begin
                    r_echo    = 1'b1;
                    r_st_byte = b;
                    if (room_reg != 11'd0)
                    begin
                        r_st_en    = 1'b1;
                        r_st_idx   = count_reg[9:0];
                        count_next = count_reg + 11'd1;
                        room_next  = room_reg - 11'd1;
                    end
                    ok_next = ok_adv;
                    if (ok_hit)
                    begin
                        r_done   = 1'b1;
                        r_status = ST_OK;
                    end
                    else
                    begin
                        err_next = err_adv;
                        if (err_hit)
                        begin
                            r_done   = 1'b1;
                            r_status = ST_ERROR;
                        end
                        else
                        begin
                            att_next = att_adv;
                            if (att_hit)
                            begin
                                r_done   = 1'b1;
                                r_status = ST_ATTACHED;
                            end
                            else
                            begin
                                nt_next = nt_adv;
                                if (nt_hit)
                                begin
                                    r_done   = 1'b1;
                                    r_status = ST_NOTICE;
                                end
                                else if (idle_reg == 16'd0)
                                begin
                                    r_done   = 1'b1;
                                    r_status = ST_TIMEOUT;
                                end
                            end
                        end
                    end
                    if (r_done)
                        active_next = 1'b0;
                end
            end
            CMD_TICK:
            begin
                if (active_reg)
                begin
                    idle_next = idle_dec;
                    if (idle_dec == 16'd0)
                    begin
                        r_done      = 1'b1;
                        r_status    = ST_TIMEOUT;
                        active_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            ok_reg        <= 3'd0;
            err_reg       <= 3'd0;
            att_reg       <= 4'd0;
            nt_reg        <= 3'd0;
            count_reg     <= 11'd0;
            room_reg      <= 11'd0;
            idle_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                active_reg <= active_next;
                ok_reg     <= ok_next;
                err_reg    <= err_next;
                att_reg    <= att_next;
                nt_reg     <= nt_next;
                count_reg  <= count_next;
                room_reg   <= room_next;
                idle_reg   <= idle_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            done_reg    <= r_done;
            status_reg  <= r_status;
            st_en_reg   <= r_st_en;
            st_idx_reg  <= r_st_idx;
            st_byte_reg <= r_st_byte;
            echo_reg    <= r_echo;
            len_reg     <= count_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign done_res        = done_reg;
    assign status          = status_reg;
    assign store_enable    = st_en_reg;
    assign store_index     = st_idx_reg;
    assign store_byte      = st_byte_reg;
    assign echo_enable     = echo_reg;
    assign received_length = len_reg;

endmodule

/* design/at_response_recognizer.sv */
`timescale 1ns / 1ps

// AT response recognizer: watches a modem receive stream for one response.
// Input channel (in_valid/in_ready): mode 0 arms with capacity and timeout_ms,
//   mode 1 carries rx_byte, mode 2 is one elapsed idle millisecond.
// Output channel (out_valid/out_ready): one result per input transfer, in order:
//   done/status, buffer write strobe with index and byte, echo strobe, length.
// Front end decodes mode and abort byte and clamps capacity, then writes a
//   two-entry command queue; the back end runs the four pattern matchers and
//   counters and holds the result in an output register.
// Path: an input transfer is written into the queue, then popped into the output
//   register when it is free or being read; the result waits there for out_ready.
// Throughput: one item per cycle while out_ready is high, set by the single
//   back-end update step (all matchers are evaluated in the same cycle).
// Stall: while the output register is held by out_ready low, the queue keeps
//   taking items until both entries fill, then in_ready drops.
// Reset: rst_n low (asynchronous) empties queue and output, and leaves the
//   recognizer unarmed with all counts at zero.
module at_response_recognizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  rx_byte,
    input  logic [10:0] capacity,
    input  logic [15:0] timeout_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        done_res,
    output logic [2:0]  status,
    output logic        store_enable,
    output logic [9:0]  store_index,
    output logic [7:0]  store_byte,
    output logic        echo_enable,
    output logic [10:0] received_length
);
    import atr_pkg::*;

    cmd_t front_cmd;
    cmd_t q_cmd;
    logic push;
    logic q_full;
    logic q_valid;
    logic pop;

    // decode and clamp, no storage
    atr_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .rx_byte    (rx_byte),
        .capacity   (capacity),
        .timeout_ms (timeout_ms),
        .q_full     (q_full),
        .push       (push),
        .cmd        (front_cmd)
    );

    // decouples intake from the back-end stall
    atr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // matchers, counters and result register
    atr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_cmd           (q_cmd),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .done_res        (done_res),
        .status          (status),
        .store_enable    (store_enable),
        .store_index     (store_index),
        .store_byte      (store_byte),
        .echo_enable     (echo_enable),
        .received_length (received_length)
    );

endmodule

/* design/atr_checker.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module atr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        done_res,
    input logic [2:0]  status,
    input logic        store_enable,
    input logic        echo_enable,
    input logic [10:0] received_length
);
    import atr_pkg::*;

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `ASSERT_IMPLY(a_store_echo, out_valid && store_enable, echo_enable && received_length != 11'd0, "store without echo or count")
    `ASSERT_IMPLY(a_bad_quiet, out_valid && status == ST_BAD, !echo_enable && !store_enable && done_res, "abort byte echoed or stored")
    `ASSERT_IMPLY(a_run_status, out_valid && !done_res, status == ST_RUN, "status set on unfinished item")
    // the queue only fills behind a stalled result
    `ASSERT_IMPLY(a_full_stalled, !in_ready, out_valid, "input blocked with no result waiting")

endmodule

bind at_response_recognizer atr_checker u_atr_checker (.*);
